>>> design/sqrs_pkg.sv
// ----------------------------------------------------------------------------
// sqrs_pkg
// shared status codes of the stable quadratic root solver
// ----------------------------------------------------------------------------
package sqrs_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_REAL  = 2'd0;
	localparam status_t ST_NEG   = 2'd1;
	localparam status_t ST_DEGEN = 2'd2;

endpackage

>>> design/sqrs_sqrt.sv
// ----------------------------------------------------------------------------
// sqrs_sqrt
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
module sqrs_sqrt #(
	parameter int RAD_W  = 66,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [RAD_W-1:0]      in_rad,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_valid,
	output logic [RAD_W/2-1:0]    out_root,
	output logic [SIDE_W-1:0]     out_side
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic              v_s    [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] y_s    [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              p_v;
		logic [RAD_W-1:0]  p_rad;
		logic [REM_W-1:0]  p_rem;
		logic [ROOT_W-1:0] p_y;
		logic [SIDE_W-1:0] p_side;
		logic [REM_W-1:0]  nr;
		logic [REM_W-1:0]  t;
		logic              ge;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_rad  = in_rad;
			assign p_rem  = '0;
			assign p_y    = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_v    = v_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_y    = y_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign nr = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
		assign t  = {p_y, 2'b01};
		assign ge = (nr >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= {p_rad[RAD_W-3:0], 2'b00};
			rem_s[k]  <= ge ? (nr - t) : nr;
			y_s[k]    <= {p_y[ROOT_W-2:0], ge};
			side_s[k] <= p_side;
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root  = y_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

>>> design/sqrs_div.sv
// ----------------------------------------------------------------------------
// sqrs_div
// pipelined restoring divider on magnitudes, one quotient bit per stage
// ----------------------------------------------------------------------------
module sqrs_div #(
	parameter int NUM_W  = 48,
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              v_s    [NUM_W];
	logic [NUM_W-1:0]  num_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  quo_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              p_v;
		logic [NUM_W-1:0]  p_num;
		logic [DEN_W-1:0]  p_den;
		logic [DEN_W-1:0]  p_rem;
		logic [NUM_W-1:0]  p_quo;
		logic [SIDE_W-1:0] p_side;
		logic [DEN_W:0]    nr;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign p_v    = in_valid;
			assign p_num  = in_num;
			assign p_den  = in_den;
			assign p_rem  = '0;
			assign p_quo  = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_v    = v_s[k-1];
			assign p_num  = num_s[k-1];
			assign p_den  = den_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_quo  = quo_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign nr   = {p_rem, p_num[NUM_W-1]};
		assign ge   = (nr >= {1'b0, p_den});
		assign diff = nr - {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k]  <= {p_num[NUM_W-2:0], 1'b0};
			den_s[k]  <= p_den;
			rem_s[k]  <= ge ? diff[DEN_W-1:0] : nr[DEN_W-1:0];
			quo_s[k]  <= {p_quo[NUM_W-2:0], ge};
			side_s[k] <= p_side;
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign out_quo   = quo_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

>>> design/stable_quadratic_root_solver.sv
// throughput: one request per cycle, busy is always low
// the square root (WORD_BITS+1 stages) and the two dividers (WORD_BITS+FRACTION_BITS
// stages, run side by side) set the depth; the receiver cannot stall
// reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// stable_quadratic_root_solver
// real roots of a*t^2+b*t+c in signed fixed point, ascending and saturated
// ----------------------------------------------------------------------------
module stable_quadratic_root_solver #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_BITS-1:0] coef_a,
	input  logic signed [WORD_BITS-1:0] coef_b,
	input  logic signed [WORD_BITS-1:0] coef_c,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] root_low,
	output logic signed [WORD_BITS-1:0] root_high,
	output sqrs_pkg::status_t           status,
	output logic                        saturated
);

	localparam int W      = WORD_BITS;
	localparam int F      = FRACTION_BITS;
	localparam int DW     = 2 * W + 2;
	localparam int RW     = W + 1;
	localparam int SQ_SW  = 3 * W + 4;
	localparam int QW     = W + F;

	assign busy = 1'b0;

	// magnitudes
	logic         v_s1;
	logic [W-1:0] am_s1, bm_s1, cm_s1;
	logic         an_s1, bn_s1, cn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		an_s1 <= coef_a[W-1];
		bn_s1 <= coef_b[W-1];
		cn_s1 <= coef_c[W-1];
		am_s1 <= coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
		bm_s1 <= coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
		cm_s1 <= coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
	end

	// products
	logic           v_s2;
	logic [2*W-1:0] b2_s2, ac_s2;
	logic [W-1:0]   am_s2, bm_s2, cm_s2;
	logic           an_s2, bn_s2, cn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		b2_s2 <= bm_s1 * bm_s1;
		ac_s2 <= am_s1 * cm_s1;
		am_s2 <= am_s1;
		bm_s2 <= bm_s1;
		cm_s2 <= cm_s1;
		an_s2 <= an_s1;
		bn_s2 <= bn_s1;
		cn_s2 <= cn_s1;
	end

	// discriminant
	logic          v_s3;
	logic [DW-1:0] disc_s3;
	logic          neg_s3;
	logic [W-1:0]  am_s3, bm_s3, cm_s3;
	logic          an_s3, bn_s3, cn_s3;
	logic [DW-1:0] b2x, ac4x;
	logic [DW:0]   diff3;

	assign b2x   = {2'b00, b2_s2};
	assign ac4x  = {ac_s2, 2'b00};
	assign diff3 = {1'b0, b2x} - {1'b0, ac4x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (an_s2 != cn_s2) begin
			disc_s3 <= b2x + ac4x;
			neg_s3  <= 1'b0;
		end else begin
			disc_s3 <= diff3[DW-1:0];
			neg_s3  <= diff3[DW];
		end
		am_s3 <= am_s2;
		bm_s3 <= bm_s2;
		cm_s3 <= cm_s2;
		an_s3 <= an_s2;
		bn_s3 <= bn_s2;
		cn_s3 <= cn_s2;
	end

	// square root
	logic             sq_valid;
	logic [RW-1:0]    sq_root;
	logic [SQ_SW-1:0] sq_side;
	logic [W-1:0]     sq_am, sq_bm, sq_cm;
	logic             sq_an, sq_bn, sq_cn, sq_neg;

	sqrs_sqrt #(
		.RAD_W  (DW),
		.SIDE_W (SQ_SW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_rad    (disc_s3),
		.in_side   ({am_s3, bm_s3, cm_s3, an_s3, bn_s3, cn_s3, neg_s3}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	assign {sq_am, sq_bm, sq_cm, sq_an, sq_bn, sq_cn, sq_neg} = sq_side;

	// q and divider operands
	logic          v_s4;
	logic [W-1:0]  qm_s4, am_s4, cm_s4;
	logic          r1n_s4, r2n_s4, neg_s4, degen_s4;
	logic [W+1:0]  qsum;
	logic [W-1:0]  qm_next;

	assign qsum    = {2'b00, sq_bm} + {1'b0, sq_root};
	assign qm_next = qsum[W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		qm_s4    <= qm_next;
		am_s4    <= sq_am;
		cm_s4    <= sq_cm;
		r1n_s4   <= (!sq_bn) ^ sq_an;
		r2n_s4   <= (!sq_bn) ^ sq_cn;
		neg_s4   <= sq_neg;
		degen_s4 <= (sq_am == '0) || (qm_next == '0);
	end

	// q/a and c/q
	logic          d1_valid, d2_valid;
	logic [QW-1:0] d1_quo, d2_quo;
	logic [2:0]    d1_side;
	logic          d2_side;

	sqrs_div #(
		.NUM_W  (QW),
		.DEN_W  (W),
		.SIDE_W (3)
	) u_div_qa (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_num    ({qm_s4, {F{1'b0}}}),
		.in_den    (am_s4),
		.in_side   ({r1n_s4, neg_s4, degen_s4}),
		.out_valid (d1_valid),
		.out_quo   (d1_quo),
		.out_side  (d1_side)
	);

	sqrs_div #(
		.NUM_W  (QW),
		.DEN_W  (W),
		.SIDE_W (1)
	) u_div_cq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_num    ({cm_s4, {F{1'b0}}}),
		.in_den    (qm_s4),
		.in_side   (r2n_s4),
		.out_valid (d2_valid),
		.out_quo   (d2_quo),
		.out_side  (d2_side)
	);

	// clamp
	localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};

	logic         v_s5;
	logic [W-1:0] r1_s5, r2_s5;
	logic         sat_s5, neg_s5, degen_s5;
	logic [W-1:0] lim1, lim2, mag1, mag2;
	logic         over1, over2;

	assign lim1  = d1_side[2] ? LIM_NEG : LIM_POS;
	assign lim2  = d2_side ? LIM_NEG : LIM_POS;
	assign over1 = d1_quo > {{F{1'b0}}, lim1};
	assign over2 = d2_quo > {{F{1'b0}}, lim2};
	assign mag1  = over1 ? lim1 : d1_quo[W-1:0];
	assign mag2  = over2 ? lim2 : d2_quo[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		r1_s5    <= d1_side[2] ? (~mag1 + 1'b1) : mag1;
		r2_s5    <= d2_side ? (~mag2 + 1'b1) : mag2;
		sat_s5   <= over1 | over2;
		neg_s5   <= d1_side[1];
		degen_s5 <= d1_side[0];
	end

	// ordering and result
	logic swap;

	assign swap = $signed(r1_s5) > $signed(r2_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s5) begin
			status    <= sqrs_pkg::ST_NEG;
			root_low  <= '0;
			root_high <= '0;
			saturated <= 1'b0;
		end else if (degen_s5) begin
			status    <= sqrs_pkg::ST_DEGEN;
			root_low  <= '0;
			root_high <= '0;
			saturated <= 1'b0;
		end else begin
			status    <= sqrs_pkg::ST_REAL;
			root_low  <= swap ? r2_s5 : r1_s5;
			root_high <= swap ? r1_s5 : r2_s5;
			saturated <= sat_s5;
		end
	end

	// checks
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		d1_valid == d2_valid)
		else $error("divider valids diverged");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == sqrs_pkg::ST_REAL || status == sqrs_pkg::ST_NEG ||
			status == sqrs_pkg::ST_DEGEN))
		else $error("unused status code");

	a_no_roots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != sqrs_pkg::ST_REAL) |->
			(root_low == '0 && root_high == '0 && !saturated))
		else $error("roots not cleared on fault status");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sqrs_pkg::ST_REAL) |-> ($signed(root_low) <= $signed(root_high)))
		else $error("roots out of order");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		d1_valid |=> ##1 done)
		else $error("result strobe missing");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives coefficient requests into the quadratic root solver and checks every
// result against an exact wide-integer prediction of discriminant, root and
// saturation behavior, under several phases of random sender idling
// ----------------------------------------------------------------------------
module testbench;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int LAT = 2*WB + FB + 7;

	typedef struct packed {
		logic [WB-1:0] a;
		logic [WB-1:0] b;
		logic [WB-1:0] c;
	} coefs_t;

	typedef struct packed {
		logic [WB-1:0]     lo;
		logic [WB-1:0]     hi;
		sqrs_pkg::status_t st;
		logic              sat;
	} roots_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [WB-1:0] coef_a, coef_b, coef_c;
	logic done;
	logic signed [WB-1:0] root_low, root_high;
	sqrs_pkg::status_t status;
	logic saturated;

	coefs_t pending_q[$];
	roots_t expected_roots_q[$];
	int errors = 0;
	int idle_pct = 0;
	bit stim_done = 0;

	stable_quadratic_root_solver #(.WORD_BITS(WB), .FRACTION_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.done(done), .root_low(root_low), .root_high(root_high),
		.status(status), .saturated(saturated)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic logic [WB-1:0] mag_of(logic [WB-1:0] v);
		return v[WB-1] ? -v : v;
	endfunction

	function automatic logic [WB-1:0] clamp(logic [191:0] m, bit neg, inout bit sat);
		logic [191:0] lim;
		logic [WB-1:0] r;
		lim = neg ? (192'd1 << (WB-1)) : ((192'd1 << (WB-1)) - 1);
		if (m > lim) begin
			m = lim;
			sat = 1;
		end
		r = m[WB-1:0];
		return neg ? -r : r;
	endfunction

	function automatic roots_t solve_quadratic(coefs_t x);
		roots_t y;
		logic [WB-1:0] am, bm, cm, r1, r2, t;
		logic [191:0] b2, ac4, disc, s, rem, bitv, qm, num, quo;
		bit qneg, sat;
		y = '0;
		sat = 0;
		am = mag_of(x.a);
		bm = mag_of(x.b);
		cm = mag_of(x.c);
		b2 = 192'(bm) * 192'(bm);
		ac4 = (192'(am) * 192'(cm)) << 2;
		if (x.a[WB-1] != x.c[WB-1])
			disc = b2 + ac4;
		else begin
			if (b2 < ac4) begin
				y.st = sqrs_pkg::ST_NEG;
				return y;
			end
			disc = b2 - ac4;
		end
		rem = disc;
		s = 0;
		bitv = 192'd1 << 190;
		while (bitv != 0 && bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= s + bitv) begin
				rem = rem - (s + bitv);
				s = (s >> 1) + bitv;
			end else
				s = s >> 1;
			bitv = bitv >> 2;
		end
		qm = (192'(bm) + s) >> 1;
		qneg = !x.b[WB-1];
		if (am == 0 || qm == 0) begin
			y.st = sqrs_pkg::ST_DEGEN;
			return y;
		end
		num = qm << FB;
		quo = num / 192'(am);
		r1 = clamp(quo, qneg != x.a[WB-1], sat);
		num = 192'(cm) << FB;
		quo = num / qm;
		r2 = clamp(quo, qneg != x.c[WB-1], sat);
		if ($signed(r1) > $signed(r2)) begin
			t = r1;
			r1 = r2;
			r2 = t;
		end
		y.lo = r1;
		y.hi = r2;
		y.st = sqrs_pkg::ST_REAL;
		y.sat = sat;
		return y;
	endfunction

	task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			coef_a <= '0;
			coef_b <= '0;
			coef_c <= '0;
		end else begin
			if (start && !busy)
				expected_roots_q.push_back(solve_quadratic({coef_a, coef_b, coef_c}));
			if ((!start || !busy) && pending_q.size() > 0 &&
			    $urandom_range(99) >= idle_pct) begin
				coefs_t p;
				p = pending_q.pop_front();
				start <= 1'b1;
				coef_a <= p.a;
				coef_b <= p.b;
				coef_c <= p.c;
			end else if (!start || !busy)
				start <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_roots_q.size() == 0) begin
				$display("unexpected result at %0t", $time);
				errors++;
			end else begin
				roots_t e;
				e = expected_roots_q.pop_front();
				if (root_low !== e.lo) report_mismatch("root_low", root_low, e.lo);
				if (root_high !== e.hi) report_mismatch("root_high", root_high, e.hi);
				if (status !== e.st) report_mismatch("status", WB'(status), WB'(e.st));
				if (saturated !== e.sat)
					report_mismatch("saturated", WB'(saturated), WB'(e.sat));
			end
		end
	end

	function automatic logic [WB-1:0] rand_coef();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1 << 18) - (1 << 17);
			2: return {$urandom} >> $urandom_range(31);
			3: return -({$urandom} >> $urandom_range(31));
			4: return 32'($signed($urandom_range(8) - 4)) << FB;
			default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	initial begin
		logic [WB-1:0] ext[6];
		ext = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: roots 1 and 2, double root, negative disc, zero a, zero q, saturation
		pending_q.push_back('{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000});
		pending_q.push_back('{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000});
		pending_q.push_back('{32'h0001_0000, 32'h0, 32'h0001_0000});
		pending_q.push_back('{32'h0, 32'h0001_0000, 32'h0001_0000});
		pending_q.push_back('{32'h0001_0000, 32'h0, 32'h0});
		pending_q.push_back('{32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001});
		pending_q.push_back('{32'h0001_0000, 32'h0, 32'hffff_0000});
		for (int i = 0; i < 18; i++)
			pending_q.push_back('{ext[$urandom_range(5)], ext[$urandom_range(5)],
				ext[$urandom_range(5)]});
		for (int ph = 0; ph < 4; ph++) begin
			while (pending_q.size() > 0) @(posedge clk);
			idle_pct = (ph == 1) ? 49 : (ph == 3) ? 30 : 0;
			for (int i = 0; i < 170; i++)
				pending_q.push_back('{rand_coef(), rand_coef(), rand_coef()});
		end
		while (pending_q.size() > 0 || start) @(posedge clk);
		while (expected_roots_q.size() > 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
design/sqrs_pkg.sv
design/sqrs_sqrt.sv
design/sqrs_div.sv
design/stable_quadratic_root_solver.sv
bench/testbench.sv
